// ===== src/vbiq_pkg.sv =====
// Shared types, constants and weight tables for the block inverse quantiser.
package vbiq_pkg;

  localparam int unsigned BlockLen      = 64;
  localparam int unsigned PosW          = 6;
  localparam logic [PosW-1:0] LastPos   = 6'd63;
  localparam logic [3:0] MaxPixelBits   = 4'd12;
  localparam logic [3:0] ResetPixelBits = 4'd8;
  localparam logic [3:0] SatShift       = 4'd3;
  localparam int unsigned IntraShift    = 3;
  localparam int unsigned InterShift    = 4;
  localparam int unsigned ProdW         = 18;
  localparam int unsigned DefQueueDepth = 4;
  localparam int unsigned CfgIdxW       = 1;
  localparam int unsigned CfgDataW      = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MATRIX_MODE = 1'b0,
    CFG_PIXEL_BITS  = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_DC,
    KIND_H263,
    KIND_MAT_INTRA,
    KIND_MAT_INTER
  } kind_e;

  typedef struct packed {
    logic signed [11:0] coeff;
    logic [4:0]         quantizer;
    logic               is_intra;
    logic [5:0]         dc_scale;
  } vbiq_in_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic [PosW-1:0]    position;
    logic               block_end;
  } vbiq_out_t;

  // one classified coefficient on its way from front to back
  typedef struct packed {
    kind_e            kind;
    logic [ProdW-1:0] prod;
    logic             neg;
    logic             zero;
    logic [4:0]       quantizer;
    logic             mismatch_en;
    logic [PosW-1:0]  position;
  } vbiq_work_t;

  localparam logic [5:0] WeightIntra [BlockLen] = '{
    6'd8,  6'd17, 6'd18, 6'd19, 6'd21, 6'd23, 6'd25, 6'd27,
    6'd17, 6'd18, 6'd19, 6'd21, 6'd23, 6'd25, 6'd27, 6'd28,
    6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd26, 6'd28, 6'd30,
    6'd21, 6'd22, 6'd23, 6'd24, 6'd26, 6'd28, 6'd30, 6'd32,
    6'd22, 6'd23, 6'd24, 6'd26, 6'd28, 6'd30, 6'd32, 6'd35,
    6'd23, 6'd24, 6'd26, 6'd28, 6'd30, 6'd32, 6'd35, 6'd38,
    6'd25, 6'd26, 6'd28, 6'd30, 6'd32, 6'd35, 6'd38, 6'd41,
    6'd27, 6'd28, 6'd30, 6'd32, 6'd35, 6'd38, 6'd41, 6'd45
  };

  localparam logic [5:0] WeightInter [BlockLen] = '{
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23,
    6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24,
    6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd26, 6'd27,
    6'd20, 6'd21, 6'd22, 6'd23, 6'd25, 6'd26, 6'd27, 6'd28,
    6'd21, 6'd22, 6'd23, 6'd24, 6'd26, 6'd27, 6'd28, 6'd30,
    6'd22, 6'd23, 6'd24, 6'd26, 6'd27, 6'd28, 6'd30, 6'd31,
    6'd23, 6'd24, 6'd25, 6'd27, 6'd28, 6'd30, 6'd31, 6'd33
  };

endpackage

// ===== src/vbiq_front.sv =====
// Front end: takes coefficients, tracks position, classifies and forms the first product.
module vbiq_front
  import vbiq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       matrix_mode_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  vbiq_in_t   in_data_i,
  input  logic       full_i,
  output logic       push_o,
  output vbiq_work_t push_data_o
);

  logic [PosW-1:0]    coeff_index_q, coeff_index_d;
  logic               in_fire;
  logic signed [12:0] coeff_ext;
  logic [12:0]        mag;
  logic [12:0]        oper_a;
  logic [5:0]         oper_b;
  logic [18:0]        prod_full;
  kind_e              kind;

  assign in_ready_o = !full_i;
  assign in_fire    = in_valid_i && !full_i;
  assign push_o     = in_fire;

  always_comb begin
    coeff_ext = 13'(in_data_i.coeff);
    mag       = coeff_ext[12] ? 13'(-coeff_ext) : 13'(coeff_ext);

    priority if (in_data_i.is_intra && coeff_index_q == '0) begin
      kind = KIND_DC;
    end else if (!matrix_mode_i) begin
      kind = KIND_H263;
    end else if (in_data_i.is_intra) begin
      kind = KIND_MAT_INTRA;
    end else begin
      kind = KIND_MAT_INTER;
    end

    unique case (kind)
      KIND_DC: begin
        oper_a = mag;
        oper_b = in_data_i.dc_scale;
      end
      KIND_H263: begin
        oper_a = mag;
        oper_b = 6'(in_data_i.quantizer);
      end
      KIND_MAT_INTRA: begin
        oper_a = mag;
        oper_b = WeightIntra[coeff_index_q];
      end
      default: begin
        // 2|c|+1 for inter weighting; |c| of 2048 still fits in 13 bits
        oper_a = 13'({mag, 1'b1});
        oper_b = WeightInter[coeff_index_q];
      end
    endcase

    prod_full = 19'(oper_a) * 19'(oper_b);

    push_data_o.kind        = kind;
    push_data_o.prod        = prod_full[ProdW-1:0];
    push_data_o.neg         = in_data_i.coeff[11];
    push_data_o.zero        = (in_data_i.coeff == '0);
    push_data_o.quantizer   = in_data_i.quantizer;
    push_data_o.mismatch_en = matrix_mode_i && !in_data_i.is_intra;
    push_data_o.position    = coeff_index_q;
  end

  // wraps from last position to zero on its own
  assign coeff_index_d = in_fire ? coeff_index_q + 1'b1 : coeff_index_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_index_q <= '0;
    end else begin
      coeff_index_q <= coeff_index_d;
    end
  end

endmodule

// ===== src/vbiq_fifo.sv =====
// Short register queue between front and back ends.
module vbiq_fifo
  import vbiq_pkg::*;
#(
  parameter int unsigned Depth = DefQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  vbiq_work_t push_data_i,
  input  logic       pop_i,
  output vbiq_work_t pop_data_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  vbiq_work_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_push_only_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> !empty_o)
    else $error("queue empty after lone write");

endmodule

// ===== src/vbiq_back.sv =====
// Back end: second product, sign, saturation, parity and mismatch control, output register.
module vbiq_back
  import vbiq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [3:0] pixel_bits_i,
  input  logic       empty_i,
  input  vbiq_work_t work_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output vbiq_out_t  out_data_o
);

  logic               out_valid_q, out_valid_d;
  logic               parity_q, parity_d;
  vbiq_out_t          out_data_q, out_data_d;
  logic [3:0]         pb;
  logic [24:0]        bound;
  logic signed [24:0] bound_hi, bound_lo;
  logic [22:0]        prod_q;
  logic signed [24:0] add_h263, mag_s, val, val_sat;
  logic [15:0]        bits;
  logic               parity;

  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  always_comb begin
    pb       = (pixel_bits_i > MaxPixelBits) ? MaxPixelBits : pixel_bits_i;
    bound    = 25'(1) << (pb + SatShift);
    bound_hi = signed'(bound - 25'd1);
    bound_lo = -signed'(bound);

    prod_q   = 23'(work_i.prod) * 23'(work_i.quantizer);
    // q for odd q, q-1 for even q (q of zero gives minus one)
    add_h263 = work_i.quantizer[0] ? signed'(25'(work_i.quantizer))
                                   : signed'(25'(work_i.quantizer)) - 25'sd1;

    unique case (work_i.kind)
      KIND_DC:        mag_s = signed'(25'(work_i.prod));
      KIND_H263:      mag_s = signed'(25'(work_i.prod) << 1) + add_h263;
      KIND_MAT_INTRA: mag_s = signed'(25'(prod_q >> IntraShift));
      default:        mag_s = signed'(25'(prod_q >> InterShift));
    endcase

    val = work_i.zero ? '0 : (work_i.neg ? -mag_s : mag_s);

    priority if (val <= bound_lo) begin
      val_sat = bound_lo;
    end else if (val >= bound_hi) begin
      val_sat = bound_hi;
    end else begin
      val_sat = val;
    end

    bits   = val_sat[15:0];
    parity = ((work_i.position == '0) ? 1'b0 : parity_q) ^ bits[0];
    // mismatch control on the last coefficient of an inter matrix block
    if (work_i.position == LastPos && work_i.mismatch_en && !parity) begin
      bits[0] = ~bits[0];
    end

    out_data_d.value     = signed'(bits);
    out_data_d.position  = work_i.position;
    out_data_d.block_end = (work_i.position == LastPos);

    parity_d    = pop_o ? parity : parity_q;
    out_valid_d = pop_o ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      parity_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      parity_q    <= parity_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== src/video_block_inverse_quantizer_core.sv =====
// Top level of the 64-coefficient block inverse quantiser.
//
// Takes quantised coefficients of 8x8 blocks in raster order and returns one
// dequantised, saturated coefficient per input with its raster position and an
// end-of-block flag. Two methods are selectable by register: H.263 style
// (2q|c| + q, or q-1 for even q) and weighted matrix (default intra / inter
// tables). The DC of an intra block is always c * dc_scale. Results saturate to
// [-2^(pixel_bits+3), 2^(pixel_bits+3)-1], pixel_bits above 12 acting as 12.
// In inter matrix mode the LSB of the last coefficient is toggled when the sum
// of the block is even. Block framing is implicit: a position counter starts at
// zero after reset and wraps every 64 transfers, so blocks must not be cut
// short. Throughput is one coefficient per clock sustained while the output is
// not stalled; each result is held in the queue and then the output register.
// The front end forms the first product (magnitude times weight, quantiser or
// DC scaler) and writes a short queue; the back end takes the second product
// by the quantiser, saturation and parity into the output register, so either
// side may stall without losing a cycle while the queue has room.
// Configuration (register 0: matrix_mode, register 1: pixel_bits, reset 0 and
// 8) is always ready and must be written only while the block is idle.
module video_block_inverse_quantizer_core
  import vbiq_pkg::*;
#(
  parameter int unsigned QueueDepth = DefQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // coefficient input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vbiq_in_t            in_data_i,
  // dequantised output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vbiq_out_t           out_data_o
);

  logic       matrix_mode_q, matrix_mode_d;
  logic [3:0] pixel_bits_q, pixel_bits_d;

  logic       push, pop, full, empty;
  vbiq_work_t push_data, pop_data;

  // Configuration registers, one write per transfer
  assign cfg_ready_o = 1'b1;

  always_comb begin
    matrix_mode_d = matrix_mode_q;
    pixel_bits_d  = pixel_bits_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_MATRIX_MODE: matrix_mode_d = cfg_data_i[0];
        CFG_PIXEL_BITS:  pixel_bits_d  = cfg_data_i[3:0];
        default:         matrix_mode_d = matrix_mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_mode_q <= 1'b0;
      pixel_bits_q  <= ResetPixelBits;
    end else begin
      matrix_mode_q <= matrix_mode_d;
      pixel_bits_q  <= pixel_bits_d;
    end
  end

  // Front end: position tracking, classification, first product
  vbiq_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .matrix_mode_i (matrix_mode_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .full_i        (full),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  // Decoupling queue
  vbiq_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (full),
    .empty_o     (empty)
  );

  // Back end: second product, saturation, mismatch control, output register
  vbiq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pixel_bits_i (pixel_bits_q),
    .empty_i      (empty),
    .work_i       (pop_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
